// ===== design/wcag_contrast_ratio_defines.svh =====
// Assertion macros used by the checker file
`ifndef WCAG_CONTRAST_RATIO_DEFINES_SVH
`define WCAG_CONTRAST_RATIO_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define WCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define WCR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/wcr_pkg.sv =====
package wcr_pkg;

  // Default fraction bits of the linear curve and luminance
  localparam int FRAC_BITS_DEF = 16;

  // Contrast result
  localparam int              RATIO_W   = 12;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 12'd2100;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 12'd100;

  // Threshold register
  localparam int                 THRESH_W     = 17;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd11731;

  // Luminance weights in Q16, summing to exactly one
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // sRGB byte to linear light, evaluated at elaboration only.
  // Upper branch: 2.4 power built as t^2 times the fifth root of t^2, in Q30.
  function automatic logic [63:0] srgb_lin(input int unsigned v, input int unsigned frac);
    logic [63:0] t, t2, lo, hi, mid, p, x, res;
    if (v <= 10) begin
      res = (((64'(v) * 64'd10) << frac) + 64'd16473) / 64'd32946;
    end else begin
      t  = ((64'd1000 * 64'(v) + 64'd14025) * Q30_ONE + 64'd134512) / 64'd269025;
      t2 = (t * t) >> 30;
      lo = '0;
      hi = Q30_ONE;
      // largest r with r^5 <= t2
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        p = mid;
        for (int k = 0; k < 4; k++) p = (p * mid) >> 30;
        if (p <= t2) lo = mid;
        else hi = mid - 64'd1;
      end
      x   = (t2 * lo) >> 30;
      res = (x + (64'd1 << (29 - frac))) >> (30 - frac);
    end
    return res;
  endfunction

endpackage

// ===== design/wcr_lum.sv =====
module wcr_lum import wcr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic [31:0]          color,
  output logic [FRAC_BITS:0]   lum
);

  localparam int LW = FRAC_BITS + 1;
  localparam int PW = LW + 16;

  typedef logic [LW-1:0] lin_tab_t [256];

  function automatic lin_tab_t build_tab();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) tab[v] = LW'(srgb_lin(v, FRAC_BITS));
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_tab();

  logic [LW-1:0] lin_r  [3];
  logic [PW-1:0] prod_r [3];
  logic [PW-1:0] sum_nxt;
  logic [LW-1:0] lum_r;

  // Stage 1: curve lookup per channel, alpha dropped
  always_ff @(posedge clk) begin
    if (en[0]) begin
      lin_r[0] <= LIN_TAB[color[23:16]];
      lin_r[1] <= LIN_TAB[color[15:8]];
      lin_r[2] <= LIN_TAB[color[7:0]];
    end
  end

  // Stage 2: weighted channels
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_r[0] <= PW'(W_RED)   * PW'(lin_r[0]);
      prod_r[1] <= PW'(W_GREEN) * PW'(lin_r[1]);
      prod_r[2] <= PW'(W_BLUE)  * PW'(lin_r[2]);
    end
  end

  // Stage 3: sum, round and drop the Q16 weight fraction
  assign sum_nxt = prod_r[0] + prod_r[1] + prod_r[2] + PW'(32768);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lum_r <= sum_nxt[PW-1:16];
    end
  end

  assign lum = lum_r;

endmodule

// ===== design/wcr_div.sv =====
module wcr_div #(
  parameter int NW = 25,
  parameter int DW = 18,
  parameter int QW = 12
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // Working width; the quotient is known to fit in QW bits
  localparam int CW = (DW + QW - 1 > NW) ? DW + QW - 1 : NW;

  logic [CW-1:0] rem_r [QW];
  logic [DW-1:0] dv_r  [QW];
  logic [QW-1:0] q_r   [QW];

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < QW; i++) begin : g_stg
    localparam int B = QW - 1 - i;
    logic [CW-1:0] rem_in;
    logic [DW-1:0] dv_in;
    logic [QW-1:0] q_in;
    logic [CW-1:0] trial;

    if (i == 0) begin : g_first
      assign rem_in = CW'(num);
      assign dv_in  = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dv_in  = dv_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign trial = CW'(dv_in) << B;

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (rem_in >= trial) begin
          rem_r[i] <= rem_in - trial;
          q_r[i]   <= q_in | (QW'(1) << B);
        end else begin
          rem_r[i] <= rem_in;
          q_r[i]   <= q_in;
        end
        dv_r[i] <= dv_in;
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== design/wcag_contrast_ratio.sv =====
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    in_color_a, in_color_b
// out_     output     out_valid / out_stall  out_contrast_x100, out_dark_foreground
// cfg_     input      cfg_valid / cfg_ready  cfg_light_threshold
//
// One colour pair per cycle while in_stall is low; each result passes through
// 3 luminance stages, 2 select/scale stages, 12 divider stages (one quotient bit
// each), 1 saturating output register.
// Reset (synchronous, rst_n low) empties the pipeline and reloads the threshold.
// A stalled output holds the pipeline only as far back as the nearest empty stage.
module wcag_contrast_ratio import wcr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input pairs
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_color_a,
  input  logic [31:0]         in_color_b,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RATIO_W-1:0]  out_contrast_x100,
  output logic                out_dark_foreground,
  // threshold register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [THRESH_W-1:0] cfg_light_threshold
);

  localparam int LW     = FRAC_BITS + 1;     // luminance, 0..1 inclusive
  localparam int NW     = LW + 8;            // 200*hi + lo
  localparam int DW     = LW + 1;            // 2*lo
  localparam int SEL_S  = 3;                 // select stage index
  localparam int DIV_S  = 5;                 // first divider stage index
  localparam int NSTG   = DIV_S + RATIO_W + 1;
  localparam logic [LW-1:0] OFFSET = LW'(((1 << FRAC_BITS) + 10) / 20);

  logic [NSTG-1:0]     vld_r;
  logic [NSTG-1:0]     en;
  logic [THRESH_W-1:0] thr_r;

  logic [LW-1:0] lum_a, lum_b;
  logic [LW-1:0] hi_nxt, lo_nxt;
  logic [LW-1:0] hi_r, lo_r;
  logic          dark_nxt;
  logic [NSTG-1:SEL_S] dark_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [RATIO_W-1:0] quo;
  logic [RATIO_W-1:0] contrast_r;

  // Threshold register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_light_threshold;
    end
  end

  // Stage enables: a stage moves unless it and everything after it is full and stalled
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = !(&vld_r[NSTG-1:i]) || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_stall = !en[0];

  // Luminance of each colour, stages 0 to 2
  wcr_lum #(.FRAC_BITS(FRAC_BITS)) u_lum_a (
    .clk   (clk),
    .en    (en[2:0]),
    .color (in_color_a),
    .lum   (lum_a)
  );

  wcr_lum #(.FRAC_BITS(FRAC_BITS)) u_lum_b (
    .clk   (clk),
    .en    (en[2:0]),
    .color (in_color_b),
    .lum   (lum_b)
  );

  // Stage 3: brighter/darker plus 0.05, threshold compare in a common scale
  always_comb begin
    if (lum_a > lum_b) begin
      hi_nxt = lum_a + OFFSET;
      lo_nxt = lum_b + OFFSET;
    end else begin
      hi_nxt = lum_b + OFFSET;
      lo_nxt = lum_a + OFFSET;
    end
    dark_nxt = {lum_a, 16'b0} > {thr_r, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[SEL_S]) begin
      hi_r          <= hi_nxt;
      lo_r          <= lo_nxt;
      dark_r[SEL_S] <= dark_nxt;
    end
  end

  // Stage 4: dividend and divisor for round-half-up of 100*hi/lo
  always_ff @(posedge clk) begin
    if (en[SEL_S+1]) begin
      num_r <= (NW'(hi_r) << 7) + (NW'(hi_r) << 6) + (NW'(hi_r) << 3) + NW'(lo_r);
      den_r <= {lo_r, 1'b0};
    end
  end

  // Flag follows its pair down the pipeline
  for (genvar i = SEL_S + 1; i < NSTG; i++) begin : g_dark
    always_ff @(posedge clk) begin
      if (en[i]) dark_r[i] <= dark_r[i-1];
    end
  end

  // Stages 5 to 16: quotient
  wcr_div #(.NW(NW), .DW(DW), .QW(RATIO_W)) u_div (
    .clk (clk),
    .en  (en[DIV_S+RATIO_W-1:DIV_S]),
    .num (num_r),
    .den (den_r),
    .quo (quo)
  );

  // Output register with saturation
  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      contrast_r <= (quo > RATIO_MAX) ? RATIO_MAX : quo;
    end
  end

  assign out_valid           = vld_r[NSTG-1];
  assign out_contrast_x100   = contrast_r;
  assign out_dark_foreground = dark_r[NSTG-1];

endmodule

// ===== design/wcr_chk.sv =====
`include "wcag_contrast_ratio_defines.svh"

module wcr_chk import wcr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [RATIO_W-1:0]  out_contrast_x100,
  input logic                out_dark_foreground
);

  // A held result keeps its value
  `WCR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_contrast_x100) && $stable(out_dark_foreground), "result changed while stalled")

  // Ratio stays within one to twenty-one
  `WCR_ASSERT(a_range, out_valid |-> out_contrast_x100 >= RATIO_MIN && out_contrast_x100 <= RATIO_MAX, "contrast out of range")

  // Input only backs up when a full pipeline meets a stalled output
  `WCR_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with room in pipeline")

  // Reset empties the pipeline
  `WCR_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind wcag_contrast_ratio wcr_chk u_chk (.*);
